[src/vlpd_pkg.sv]
// Shared types and constants of the varint length prefix deframer.
package vlpd_pkg;

    localparam int PREFIX_MAX  = 10;
    localparam int LAST_IDX    = 9;
    localparam int PFX_IDX_W   = $clog2(PREFIX_MAX);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] LOW_MASK = 7'h7f;
    localparam logic [7:0] CONT_BIT = 8'h80;

    localparam logic [1:0] ERR_OVERFLOW  = 2'd0;
    localparam logic [1:0] ERR_NONCANON  = 2'd1;
    localparam logic [1:0] ERR_MAX_FRAME = 2'd2;
    localparam logic [1:0] ERR_BUFFER    = 2'd3;

    localparam logic [7:0] CFG_MAX_FRAME_ENABLE = 8'd0;
    localparam logic [7:0] CFG_MAX_FRAME_LENGTH = 8'd1;
    localparam logic [7:0] CFG_INCLUDE_PREFIX   = 8'd2;
    localparam logic [7:0] CFG_BUFFER_LIMIT     = 8'd3;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_REPLAY,
        CMD_EMPTY,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                      kind;
        logic [7:0]                     data;
        logic                           last;
        logic [1:0]                     code;
        logic [PFX_IDX_W-1:0]           count;
        logic [PREFIX_MAX-1:0][7:0]     prefix;
    } cmd_t;

    typedef struct packed {
        logic        max_frame_enable;
        logic [63:0] max_frame_length;
        logic        emit_prefix;
        logic [63:0] buffer_limit;
    } cfg_t;

endpackage

[src/varint_length_prefix_deframer.sv]
// Top level of the LEB128 length prefix deframer with its configuration registers.
// Each input item is one stream byte. The block reads an unsigned canonical LEB128
// length of up to ten bytes, checks it against the optional maximum frame length and
// the buffer limit, then passes the payload bytes through, flagging the last byte of
// each message. With prefix emission enabled the prefix bytes are replayed ahead of the
// payload; a zero-length message without prefix replay yields one empty-frame item.
// A framing error yields one error item, after which input bytes are taken and dropped
// until reset. Prefix and payload bytes are taken at one item per cycle while the
// two-entry command queue has room; the output register emits one item per cycle while
// m_ready is high, so a replayed prefix holds the back end for one item per byte and
// the input stalls once the queue fills. Configuration writes apply on the next cycle.
module varint_length_prefix_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_last,
    output logic        m_empty_frame,
    output logic        m_error_valid,
    output logic [1:0]  m_error_code
);
    import vlpd_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    cmd_t head_cmd;
    logic q_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_FRAME_ENABLE: cfg_next.max_frame_enable = cfg_wr_data[0];
                CFG_MAX_FRAME_LENGTH: cfg_next.max_frame_length = cfg_wr_data;
                CFG_INCLUDE_PREFIX:   cfg_next.emit_prefix      = cfg_wr_data[0];
                CFG_BUFFER_LIMIT:     cfg_next.buffer_limit     = cfg_wr_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frame_enable <= 1'b0;
            cfg_reg.max_frame_length <= 64'd0;
            cfg_reg.emit_prefix      <= 1'b0;
            cfg_reg.buffer_limit     <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vlpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    vlpd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    vlpd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_last  (m_frame_last),
        .m_empty_frame (m_empty_frame),
        .m_error_valid (m_error_valid),
        .m_error_code  (m_error_code)
    );

endmodule

[src/vlpd_front.sv]
// Front end: accepts stream bytes, parses the length prefix and issues commands.
module vlpd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  vlpd_pkg::cfg_t cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    input  logic           q_full,
    output logic           q_push,
    output vlpd_pkg::cmd_t q_cmd
);
    import vlpd_pkg::*;

    phase_t                     phase_reg, phase_next;
    logic [63:0]                acc_reg, acc_next;
    logic [PFX_IDX_W-1:0]       count_reg, count_next;
    logic [63:0]                rem_reg, rem_next;
    logic [PREFIX_MAX-1:0][7:0] store_reg, store_new;
    logic                       store_we;

    logic                       accept;
    logic [PFX_IDX_W-1:0]       idx;
    logic [PFX_IDX_W-1:0]       n;
    logic [6:0]                 low;
    logic                       cont;
    logic [6:0]                 shamt;
    logic [63:0]                acc_new;
    logic                       overflow;
    logic                       noncanon;
    logic                       err_max;
    logic                       err_buf;
    logic                       plen_zero;
    logic                       rem_one;

    assign accept    = s_valid && s_ready;
    assign low       = s_data_byte[6:0] & LOW_MASK;
    assign cont      = (s_data_byte & CONT_BIT) != 8'd0;
    assign idx       = (count_reg >= PFX_IDX_W'(LAST_IDX)) ? PFX_IDX_W'(LAST_IDX) : count_reg;
    assign n         = idx + PFX_IDX_W'(1);
    assign shamt     = 7'(idx) * 7'd7;
    assign acc_new   = acc_reg | ({57'd0, low} << shamt);
    assign overflow  = (idx == PFX_IDX_W'(LAST_IDX)) && ((low > 7'd1) || cont);
    assign noncanon  = !cont && (idx != '0) && (low == 7'd0);
    assign err_max   = cfg.max_frame_enable && (acc_new > cfg.max_frame_length);
    // The second term is only meaningful when the length fits the limit.
    assign err_buf   = (acc_new > cfg.buffer_limit) ||
                       ({{(64-PFX_IDX_W){1'b0}}, n} > (cfg.buffer_limit - acc_new));
    assign plen_zero = (acc_new == 64'd0);
    assign rem_one   = (rem_reg == 64'd1);

    always_comb begin
        store_new      = store_reg;
        store_new[idx] = s_data_byte;
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_PREFIX: begin
                if (accept) begin
                    if (overflow) begin
                        phase_next = PH_HALT;
                    end else if (!cont) begin
                        if (noncanon || err_max || err_buf) begin
                            phase_next = PH_HALT;
                        end else if (!plen_zero) begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (accept && rem_one) begin
                    phase_next = PH_PREFIX;
                end
            end
            PH_HALT: phase_next = PH_HALT;
            default: phase_next = PH_PREFIX;
        endcase
    end

    always_comb begin
        s_ready    = !q_full;
        q_push     = 1'b0;
        q_cmd      = '0;
        q_cmd.kind = CMD_BYTE;
        q_cmd.prefix = store_new;
        acc_next   = acc_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        store_we   = 1'b0;
        case (phase_reg)
            PH_PREFIX: begin
                if (accept) begin
                    store_we = !overflow;
                    acc_next = acc_new;
                    if (overflow) begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_ERROR;
                        q_cmd.code = ERR_OVERFLOW;
                    end else if (cont) begin
                        count_next = n;
                    end else if (noncanon) begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_ERROR;
                        q_cmd.code = ERR_NONCANON;
                    end else if (err_max) begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_ERROR;
                        q_cmd.code = ERR_MAX_FRAME;
                    end else if (err_buf) begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_ERROR;
                        q_cmd.code = ERR_BUFFER;
                    end else begin
                        acc_next   = 64'd0;
                        count_next = '0;
                        rem_next   = acc_new;
                        if (cfg.emit_prefix) begin
                            q_push      = 1'b1;
                            q_cmd.kind  = CMD_REPLAY;
                            q_cmd.count = n;
                            q_cmd.last  = plen_zero;
                        end else if (plen_zero) begin
                            q_push     = 1'b1;
                            q_cmd.kind = CMD_EMPTY;
                            q_cmd.last = 1'b1;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                if (accept) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_BYTE;
                    q_cmd.data = s_data_byte;
                    q_cmd.last = rem_one;
                    rem_next   = rem_reg - 64'd1;
                end
            end
            PH_HALT: begin
                // Bytes after an error are taken and dropped.
                s_ready = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            acc_reg   <= 64'd0;
            count_reg <= '0;
            rem_reg   <= 64'd0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg <= store_new;
        end
    end

endmodule

[src/vlpd_queue.sv]
// Short command queue between the front end and the back end.
module vlpd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vlpd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output vlpd_pkg::cmd_t head_cmd,
    output logic           empty
);
    import vlpd_pkg::*;

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/vlpd_back.sv]
// Back end: carries out queued commands into the registered result channel.
module vlpd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  vlpd_pkg::cmd_t head_cmd,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_frame_last,
    output logic           m_empty_frame,
    output logic           m_error_valid,
    output logic [1:0]     m_error_code
);
    import vlpd_pkg::*;

    logic                 valid_reg, valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic                 empty_reg, empty_next;
    logic                 err_reg, err_next;
    logic [1:0]           code_reg, code_next;
    logic [PFX_IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic                 out_load;
    logic                 rep_final;

    assign out_load  = !valid_reg || m_ready;
    assign rep_final = (rep_idx_reg == head_cmd.count - PFX_IDX_W'(1));

    always_comb begin
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        empty_next   = empty_reg;
        err_next     = err_reg;
        code_next    = code_reg;
        rep_idx_next = rep_idx_reg;
        q_pop        = 1'b0;
        if (out_load) begin
            valid_next = !q_empty;
            byte_next  = 8'd0;
            last_next  = 1'b0;
            empty_next = 1'b0;
            err_next   = 1'b0;
            code_next  = 2'd0;
            if (!q_empty) begin
                case (head_cmd.kind)
                    CMD_BYTE: begin
                        byte_next = head_cmd.data;
                        last_next = head_cmd.last;
                        q_pop     = 1'b1;
                    end
                    CMD_REPLAY: begin
                        byte_next = head_cmd.prefix[rep_idx_reg];
                        last_next = head_cmd.last && rep_final;
                        if (rep_final) begin
                            q_pop        = 1'b1;
                            rep_idx_next = '0;
                        end else begin
                            rep_idx_next = rep_idx_reg + PFX_IDX_W'(1);
                        end
                    end
                    CMD_EMPTY: begin
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                        q_pop      = 1'b1;
                    end
                    CMD_ERROR: begin
                        err_next  = 1'b1;
                        code_next = head_cmd.code;
                        q_pop     = 1'b1;
                    end
                    default: begin
                        q_pop = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            rep_idx_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            rep_idx_reg <= rep_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        err_reg   <= err_next;
        code_reg  <= code_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_frame_last  = last_reg;
    assign m_empty_frame = empty_reg;
    assign m_error_valid = err_reg;
    assign m_error_code  = code_reg;

endmodule
